### hw/rtl/pfce_pkg.sv
// ----------------------------------------------------------------------------
// pfce_pkg
// Types, codes and default sizes shared by the packet field counter engine.
// ----------------------------------------------------------------------------
package pfce_pkg;

	localparam int TEMPLATES_DEF = 64;
	localparam int SLOTS_DEF     = 16;
	localparam int RESULT_LIMIT  = 16;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_COUNT = 2'd1,
		CMD_APPLY = 2'd2,
		CMD_NONE  = 2'd3
	} pfce_cmd_t;

	typedef enum logic [1:0] {
		ST_PATCH    = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_REJECTED = 2'd2,
		ST_ACCEPTED = 2'd3
	} pfce_status_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  template_index;
		logic [3:0]  slot_index;
		logic [4:0]  active_count;
		logic [15:0] byte_offset;
		logic [7:0]  lower_bound;
		logic [7:0]  upper_bound;
		logic [7:0]  step_size;
		logic        count_down;
		logic [7:0]  start_value;
	} pfce_req_t;

	typedef struct packed {
		logic [15:0] patch_offset;
		logic [7:0]  patch_byte;
		logic [1:0]  status;
		logic        last;
	} pfce_res_t;

	// one counter entry as kept in the table memory
	typedef struct packed {
		logic [7:0]  lower;
		logic [7:0]  upper;
		logic [7:0]  step;
		logic        down;
		logic [15:0] position;
		logic [7:0]  current;
	} pfce_entry_t;

endpackage

### hw/rtl/pfce_ram.sv
// ----------------------------------------------------------------------------
// pfce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/packet_field_counter_engine_unit.sv
// ----------------------------------------------------------------------------
// packet_field_counter_engine_unit
// Write, count and apply commands over per-template byte counter tables.
// Write and count: one result the cycle after start, busy stays low.
// Apply: busy from start; no active counters gives one empty result from S_CNT,
//   else each patch is worked out in S_RD, S_LOAD, S_DIV and S_FIX (read, load,
//   8 remainder steps, update), one patch after another, in one shared
//   9-bit subtractor; busy is low again in the cycle of the last patch.
// Reset clears the sequencer and all active counts; counter entries are
//   undefined until written. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module packet_field_counter_engine_unit
	import pfce_pkg::*;
#(
	parameter int TEMPLATES = TEMPLATES_DEF,
	parameter int SLOTS     = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  pfce_req_t request,
	output logic      result_valid,
	output pfce_res_t result
);

	// only 64 templates and 16 slots are addressable through the ports
	localparam int ACT_DEPTH = (TEMPLATES < 64) ? TEMPLATES : 64;
	localparam int SLOT_USE  = (SLOTS < 16) ? SLOTS : 16;
	localparam int CNT_MAX   = (SLOT_USE < RESULT_LIMIT) ? SLOT_USE : RESULT_LIMIT;
	localparam int ENT_DEPTH = ACT_DEPTH * SLOT_USE;
	localparam int TAW       = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int AW        = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
	localparam int EW        = $bits(pfce_entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CNT,
		S_RD,
		S_LOAD,
		S_DIV,
		S_FIX
	} state_t;

	state_t      state_q;
	pfce_res_t   res_q;
	logic        res_vld_q;
	logic [5:0]  tpl_q;
	logic        act_hit_q;
	logic [4:0]  j_q;
	logic [4:0]  n_q;
	logic [2:0]  bit_q;
	logic [8:0]  size_q;
	logic [8:0]  rem_q;
	pfce_entry_t ent_q;
	logic        act_vld_q [ACT_DEPTH];

	logic        accept;
	logic        tpl_bad;
	logic        wr_bad;
	logic        cnt_bad;
	pfce_status_t idle_st;
	logic [AW-1:0] req_addr;
	logic [AW-1:0] cur_addr;

	logic        ent_we;
	logic [AW-1:0] ent_waddr;
	pfce_entry_t ent_wdata;
	logic        ent_re;
	pfce_entry_t ent_rdata;

	logic        act_we;
	logic [4:0]  act_rdata;

	// shared subtract/compare unit
	logic [8:0]  opa;
	logic [9:0]  diff;
	logic        no_borrow;
	logic [8:0]  rel;
	logic [8:0]  fix_sum;
	logic [8:0]  fix_mod;
	logic [7:0]  new_val;
	logic        last_slot;
	pfce_entry_t new_ent;

	assign accept  = start && !busy;
	assign tpl_bad = (32'(request.template_index) >= TEMPLATES)
		|| (request.cmd == CMD_NONE);
	assign wr_bad  = (32'(request.slot_index) >= SLOTS)
		|| (request.upper_bound < request.lower_bound)
		|| (request.start_value < request.lower_bound)
		|| (request.start_value > request.upper_bound);
	assign cnt_bad = 32'(request.active_count) > CNT_MAX;

	assign idle_st = (tpl_bad || (request.cmd == CMD_WRITE && wr_bad)
		|| (request.cmd == CMD_COUNT && cnt_bad)) ? ST_REJECTED : ST_ACCEPTED;

	assign req_addr = AW'(32'(request.template_index) * SLOT_USE
		+ 32'(request.slot_index));
	assign cur_addr = AW'(32'(tpl_q) * SLOT_USE + 32'(j_q));

	assign rel     = {1'b0, ent_q.current - ent_q.lower};
	assign fix_sum = ent_q.down ? (rel + size_q - rem_q) : (rel + rem_q);

	always_comb begin
		if (state_q == S_DIV) begin
			opa = {rem_q[7:0], ent_q.step[bit_q]};
		end else begin
			opa = fix_sum;
		end
	end

	assign diff      = {1'b0, opa} - {1'b0, size_q};
	assign no_borrow = !diff[9];
	assign fix_mod   = no_borrow ? diff[8:0] : opa;
	assign new_val   = fix_mod[7:0] + ent_q.lower;
	assign last_slot = (j_q + 5'd1) == n_q;

	always_comb begin
		new_ent         = ent_q;
		new_ent.current = new_val;
	end

	// table write: either a write command or the apply write-back
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = req_addr;
		ent_wdata = '{lower: request.lower_bound, upper: request.upper_bound,
			step: request.step_size, down: request.count_down,
			position: request.byte_offset, current: request.start_value};
		if (state_q == S_FIX) begin
			ent_we    = 1'b1;
			ent_waddr = cur_addr;
			ent_wdata = new_ent;
		end else if (accept && !tpl_bad && request.cmd == CMD_WRITE && !wr_bad) begin
			ent_we = 1'b1;
		end
	end

	assign ent_re = (state_q == S_RD);
	assign act_we = accept && !tpl_bad && request.cmd == CMD_COUNT && !cnt_bad;

	pfce_ram #(
		.WIDTH(EW),
		.DEPTH(ENT_DEPTH)
	) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(cur_addr),
		.rdata(ent_rdata)
	);

	pfce_ram #(
		.WIDTH(5),
		.DEPTH(ACT_DEPTH)
	) u_act_ram (
		.clk  (clk),
		.we   (act_we),
		.waddr(request.template_index[TAW-1:0]),
		.wdata(request.active_count),
		.re   (accept),
		.raddr(request.template_index[TAW-1:0]),
		.rdata(act_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_q     <= '0;
			res_vld_q <= 1'b0;
			tpl_q     <= '0;
			act_hit_q <= 1'b0;
			j_q       <= '0;
			n_q       <= '0;
			bit_q     <= '0;
			size_q    <= '0;
			rem_q     <= '0;
			ent_q     <= '0;
			for (int i = 0; i < ACT_DEPTH; i++) begin
				act_vld_q[i] <= 1'b0;
			end
		end else begin
			res_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						tpl_q     <= request.template_index;
						act_hit_q <= act_vld_q[request.template_index[TAW-1:0]];
						res_q     <= '{patch_offset: '0, patch_byte: '0,
							status: idle_st, last: 1'b1};
						if (tpl_bad) begin
							res_vld_q <= 1'b1;
						end else begin
							unique case (request.cmd)
								CMD_WRITE: begin
									res_vld_q <= 1'b1;
								end
								CMD_COUNT: begin
									res_vld_q <= 1'b1;
									if (!cnt_bad) begin
										act_vld_q[request.template_index[TAW-1:0]] <= 1'b1;
									end
								end
								default: begin
									state_q <= S_CNT;
								end
							endcase
						end
					end
				end
				S_CNT: begin
					j_q <= '0;
					if (!act_hit_q || act_rdata == 5'd0) begin
						res_vld_q    <= 1'b1;
						res_q.status <= ST_EMPTY;
						state_q      <= S_IDLE;
					end else begin
						n_q     <= act_rdata;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					ent_q   <= ent_rdata;
					size_q  <= {1'b0, ent_rdata.upper} - {1'b0, ent_rdata.lower} + 9'd1;
					rem_q   <= '0;
					bit_q   <= 3'd7;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring remainder: step mod range size, one bit a cycle
					rem_q <= no_borrow ? diff[8:0] : opa;
					if (bit_q == 3'd0) begin
						state_q <= S_FIX;
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				S_FIX: begin
					res_vld_q <= 1'b1;
					res_q     <= '{patch_offset: ent_q.position, patch_byte: new_val,
						status: ST_PATCH, last: last_slot};
					if (last_slot) begin
						state_q <= S_IDLE;
					end else begin
						j_q     <= j_q + 5'd1;
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

### sim/pfce_checker.sv
// ----------------------------------------------------------------------------
// pfce_checker
// Watches the command and result channels of the packet field counter engine.
// Keeps its own copy of the counter tables, works out the results of every
// accepted transaction and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module pfce_checker
	import pfce_pkg::*;
#(
	parameter int TEMPLATES = TEMPLATES_DEF,
	parameter int SLOTS     = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  pfce_req_t request,
	input  logic      result_valid,
	input  pfce_res_t result,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	pfce_entry_t counter_tbl [TEMPLATES*SLOTS];
	logic [4:0]  active_slots [TEMPLATES];
	pfce_res_t   patch_q [$];

	// step within [lower, upper], wrapping modulo the range size
	function automatic logic [7:0] next_counter(pfce_entry_t e);
		int span;
		int rel;
		int inc;
		span = int'(e.upper) - int'(e.lower) + 1;
		rel  = int'(e.current) - int'(e.lower);
		inc  = int'(e.step) % span;
		if (e.down) begin
			rel = (rel + span - inc) % span;
		end else begin
			rel = (rel + inc) % span;
		end
		return 8'(rel + int'(e.lower));
	endfunction

	function automatic void push_status(pfce_status_t st);
		pfce_res_t res;
		res        = '0;
		res.status = st;
		res.last   = 1'b1;
		patch_q.push_back(res);
	endfunction

	function automatic void predict_transaction(pfce_req_t r);
		int          tpl;
		int          idx;
		int          n;
		pfce_entry_t e;
		pfce_res_t   res;
		tpl = int'(r.template_index);
		if (tpl >= TEMPLATES) begin
			push_status(ST_REJECTED);
		end else begin
			case (pfce_cmd_t'(r.cmd))
				CMD_WRITE: begin
					if (int'(r.slot_index) >= SLOTS || r.upper_bound < r.lower_bound ||
					    r.start_value < r.lower_bound || r.start_value > r.upper_bound) begin
						push_status(ST_REJECTED);
					end else begin
						e.lower    = r.lower_bound;
						e.upper    = r.upper_bound;
						e.step     = r.step_size;
						e.down     = r.count_down;
						e.position = r.byte_offset;
						e.current  = r.start_value;
						counter_tbl[tpl*SLOTS + int'(r.slot_index)] = e;
						push_status(ST_ACCEPTED);
					end
				end
				CMD_COUNT: begin
					if (int'(r.active_count) > SLOTS || int'(r.active_count) > RESULT_LIMIT) begin
						push_status(ST_REJECTED);
					end else begin
						active_slots[tpl] = r.active_count;
						push_status(ST_ACCEPTED);
					end
				end
				CMD_APPLY: begin
					n = int'(active_slots[tpl]);
					if (n > SLOTS) n = SLOTS;
					if (n > RESULT_LIMIT) n = RESULT_LIMIT;
					if (n == 0) begin
						push_status(ST_EMPTY);
					end else begin
						for (int j = 0; j < n; j++) begin
							idx = tpl*SLOTS + j;
							counter_tbl[idx].current = next_counter(counter_tbl[idx]);
							res.patch_offset = counter_tbl[idx].position;
							res.patch_byte   = counter_tbl[idx].current;
							res.status       = ST_PATCH;
							res.last         = (j == n - 1);
							patch_q.push_back(res);
						end
					end
				end
				default: push_status(ST_REJECTED);
			endcase
		end
	endfunction

	function automatic void check_result(pfce_res_t got);
		pfce_res_t want;
		if (patch_q.size() == 0) begin
			$error("unexpected result: offset %0d byte %0d status %0d last %0d",
			       got.patch_offset, got.patch_byte, got.status, got.last);
			fail_count++;
		end else begin
			want = patch_q.pop_front();
			if (got.patch_offset !== want.patch_offset) begin
				$error("patch_offset: expected %0d, got %0d", want.patch_offset, got.patch_offset);
				fail_count++;
			end
			if (got.patch_byte !== want.patch_byte) begin
				$error("patch_byte: expected %0d, got %0d", want.patch_byte, got.patch_byte);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				fail_count++;
			end
		end
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// results are compared before the transaction of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_q.delete();
			for (int t = 0; t < TEMPLATES; t++) active_slots[t] = '0;
		end else begin
			if (result_valid) check_result(result);
			if (start && !busy) predict_transaction(request);
		end
		pending = patch_q.size();
	end

endmodule

### sim/tb_packet_field_counter_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_packet_field_counter_engine_unit
// Drives write, count and apply transactions into the counter engine, first
// a directed set of corner cases, then random template build-up sequences
// mixed with noise, in bursts with random gaps. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_packet_field_counter_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pfce_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 330;
	localparam int TAIL_CYCLES    = 40;

	logic      clk     = 1'b0;
	logic      arst_n  = 1'b0;
	logic      start   = 1'b0;
	pfce_req_t request = '0;
	logic      busy;
	logic      result_valid;
	pfce_res_t result;
	int        fail_count;
	int        pending;

	// slots holding a stored entry; counts never reach past the written prefix
	logic [SLOTS_DEF-1:0] written_mask [TEMPLATES_DEF];
	int burst_left;
	int sent_count;
	int stop_at;
	int quiet_cycles;

	always #2 clk = ~clk;

	packet_field_counter_engine_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	pfce_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// nothing accepted and no result for too long: hang
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int prefix_len(int tpl);
		int n;
		n = 0;
		while (n < SLOTS_DEF && written_mask[tpl][n]) n++;
		return n;
	endfunction

	function automatic pfce_req_t noise_req();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(pfce_req_t)-1:0];
	endfunction

	function automatic pfce_req_t cmd_req(pfce_cmd_t c, int tpl, int cnt);
		pfce_req_t r;
		r                = noise_req();
		r.cmd            = c;
		r.template_index = 6'(tpl);
		r.active_count   = 5'(cnt);
		return r;
	endfunction

	function automatic pfce_req_t entry_req(int tpl, int slot, int lo, int hi, int step,
	                                        int down, int sv, int off);
		pfce_req_t r;
		r             = cmd_req(CMD_WRITE, tpl, $urandom_range(0, 31));
		r.slot_index  = 4'(slot);
		r.lower_bound = 8'(lo);
		r.upper_bound = 8'(hi);
		r.step_size   = 8'(step);
		r.count_down  = 1'(down);
		r.start_value = 8'(sv);
		r.byte_offset = 16'(off);
		return r;
	endfunction

	function automatic pfce_req_t random_write(int tpl, int slot, bit good);
		int lo;
		int hi;
		int sv;
		int step;
		int a;
		int b;
		sv = $urandom_range(0, 255);
		if (good) begin
			case ($urandom_range(0, 7))
				0: begin
					lo = 0;
					hi = 255;
				end
				1: begin
					lo = $urandom_range(0, 255);
					hi = lo;
				end
				default: begin
					a  = $urandom_range(0, 255);
					b  = $urandom_range(0, 255);
					lo = (a < b) ? a : b;
					hi = (a < b) ? b : a;
				end
			endcase
			sv = $urandom_range(lo, hi);
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					lo = $urandom_range(1, 255);
					hi = $urandom_range(0, lo - 1);
				end
				1: begin
					lo = $urandom_range(1, 255);
					hi = $urandom_range(lo, 255);
					sv = $urandom_range(0, lo - 1);
				end
				default: begin
					hi = $urandom_range(0, 254);
					lo = $urandom_range(0, hi);
					sv = $urandom_range(hi + 1, 255);
				end
			endcase
		end
		case ($urandom_range(0, 7))
			0:       step = 0;
			1:       step = 255;
			default: step = $urandom_range(0, 255);
		endcase
		return entry_req(tpl, slot, lo, hi, step, $urandom_range(0, 1), sv,
		                 $urandom_range(0, 65535));
	endfunction

	task automatic pause_sender(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// hold start until the transaction is taken, then idle per burst pattern
	task automatic send_item(pfce_req_t r);
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		while (busy) @(negedge clk);
		@(posedge clk);
		sent_count++;
		if (r.cmd == CMD_WRITE && r.upper_bound >= r.lower_bound &&
		    r.start_value >= r.lower_bound && r.start_value <= r.upper_bound)
			written_mask[r.template_index][r.slot_index] = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pause_sender($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
			                                          : $urandom_range(0, 7);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// fill a template's leading slots, activate them, apply a few times
	task automatic build_template();
		int tpl;
		int n;
		tpl = $urandom_range(0, TEMPLATES_DEF - 1);
		n   = ($urandom_range(0, 4) == 0) ? SLOTS_DEF : $urandom_range(1, SLOTS_DEF);
		for (int s = 0; s < n; s++) begin
			if (!written_mask[tpl][s] || $urandom_range(0, 2) == 0)
				send_item(random_write(tpl, s, 1'b1));
		end
		send_item(cmd_req(CMD_COUNT, tpl, n));
		repeat ($urandom_range(1, 4)) send_item(cmd_req(CMD_APPLY, tpl, $urandom_range(0, 31)));
	endtask

	task automatic send_noise();
		int tpl;
		tpl = $urandom_range(0, TEMPLATES_DEF - 1);
		case ($urandom_range(0, 5))
			0: send_item(random_write(tpl, $urandom_range(0, SLOTS_DEF - 1), 1'b1));
			1: send_item(random_write(tpl, $urandom_range(0, SLOTS_DEF - 1), 1'b0));
			2: send_item(cmd_req(CMD_COUNT, tpl, $urandom_range(0, prefix_len(tpl))));
			3: send_item(cmd_req(CMD_COUNT, tpl, $urandom_range(17, 31)));
			4: send_item(cmd_req(CMD_APPLY, tpl, $urandom_range(0, 31)));
			default: send_item(cmd_req(CMD_NONE, tpl, $urandom_range(0, 31)));
		endcase
	endtask

	initial begin
		for (int t = 0; t < TEMPLATES_DEF; t++) written_mask[t] = '0;
		burst_left = $urandom_range(0, 7);
		sent_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// full range with maximal step, down wrap, single value, zero step
		send_item(entry_req(0, 0, 0, 255, 255, 0, 250, 16'hFFFF));
		send_item(entry_req(0, 1, 10, 20, 3, 1, 10, 16'h0000));
		send_item(entry_req(0, 2, 77, 77, 9, 0, 77, 16'h1234));
		send_item(entry_req(0, 3, 5, 200, 0, 1, 100, 16'h8000));
		send_item(entry_req(0, 4, 0, 255, 1, 1, 0, 16'h00FF));
		send_item(entry_req(63, 15, 100, 103, 200, 0, 103, 16'h7FFF));
		send_item(cmd_req(CMD_COUNT, 0, 5));
		send_item(cmd_req(CMD_APPLY, 0, 0));
		send_item(cmd_req(CMD_APPLY, 0, 31));
		// rejected entries: inverted bounds, start below and above the range
		send_item(entry_req(0, 5, 9, 8, 1, 0, 9, 16'h0001));
		send_item(entry_req(0, 5, 50, 60, 1, 0, 49, 16'h0002));
		send_item(entry_req(0, 5, 50, 60, 1, 0, 61, 16'h0003));
		send_item(cmd_req(CMD_COUNT, 0, 17));
		send_item(cmd_req(CMD_COUNT, 0, 31));
		send_item(cmd_req(CMD_NONE, 0, 0));
		send_item(cmd_req(CMD_APPLY, 1, 0));
		send_item(cmd_req(CMD_COUNT, 0, 0));
		send_item(cmd_req(CMD_APPLY, 0, 0));
		send_item(cmd_req(CMD_COUNT, 0, 5));
		send_item(cmd_req(CMD_APPLY, 0, 16));
		send_item(cmd_req(CMD_COUNT, 63, 0));
		send_item(cmd_req(CMD_APPLY, 63, 0));
		drain_results();

		stop_at = sent_count + RANDOM_ITEMS;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 9) < 6) begin
				build_template();
			end else begin
				send_noise();
			end
			if ($urandom_range(0, 7) == 0) drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
